FILE: rtl/s2h_pkg.sv
// shared types, widths and reset constants of the 2d histogram sampler
`default_nettype none

package s2h_pkg;

   // default table geometry
   localparam int DEF_MAX_ROWS   = 128;
   localparam int DEF_MAX_COLS   = 128;
   localparam int DEF_COUNT_BITS = 24;

   // fixed field widths of the channels
   localparam int IDX_W      = 7;
   localparam int CNT_W      = 24;
   localparam int RAND_W     = 32;
   localparam int VAL_W      = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [7:0]  ROWS_RST    = 8'd120;
   localparam logic [7:0]  COLS_RST    = 8'd100;
   localparam logic [15:0] ROW_OFF_RST = 16'd100;
   localparam logic [15:0] COL_OFF_RST = 16'd20;
   localparam logic [7:0]  STEP_RST    = 8'd4;

   // which walk the scan engine performs
   typedef enum logic [1:0] {
      SCAN_TOT,
      SCAN_ROW,
      SCAN_COL,
      SCAN_RESCAN
   } scan_kind_type;

   // steps of the shared fraction multiply
   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_LO,
      MUL_HI,
      MUL_SUM
   } mul_step_type;

   // controller to datapath
   typedef struct packed {
      logic          clear_step;
      logic          capture;
      logic          ld_read;
      logic          ld_write;
      logic          scan_start;
      logic          scan_run;
      scan_kind_type scan_kind;
      mul_step_type  mul_step;
      logic          mul_col;
      logic          out_load;
   } s2h_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic scan_done;
      logic dirty;
      logic total_zero;
      logic out_free;
   } s2h_status_type;

endpackage

`default_nettype wire

FILE: rtl/s2h_ctrl.sv
// controller state machine of the 2d histogram sampler
`default_nettype none

module s2h_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_mode,
   output logic                    req_stall,
   input  s2h_pkg::s2h_status_type status,
   output s2h_pkg::s2h_cmd_type    cmd
);
   import s2h_pkg::*;

   localparam logic MODE_LOAD = 1'b0;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_READ,
      ST_LD_WRITE,
      ST_RS_GO,
      ST_RS_RUN,
      ST_TOT_GO,
      ST_TOT_RUN,
      ST_MR_LO,
      ST_MR_HI,
      ST_MR_SUM,
      ST_ROW_GO,
      ST_ROW_RUN,
      ST_MC_LO,
      ST_MC_HI,
      ST_MC_SUM,
      ST_COL_GO,
      ST_COL_RUN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_mode == MODE_LOAD) state_in = ST_LD_READ;
               else if (status.dirty)     state_in = ST_RS_GO;
               else                       state_in = ST_TOT_GO;
            end
         end
         ST_LD_READ: begin
            cmd.ld_read = 1'b1;
            state_in    = ST_LD_WRITE;
         end
         ST_LD_WRITE: begin
            cmd.ld_write = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_RS_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_kind  = SCAN_RESCAN;
            state_in       = ST_RS_RUN;
         end
         ST_RS_RUN: begin
            cmd.scan_run  = 1'b1;
            cmd.scan_kind = SCAN_RESCAN;
            if (status.scan_done) state_in = ST_TOT_GO;
         end
         ST_TOT_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_kind  = SCAN_TOT;
            state_in       = ST_TOT_RUN;
         end
         ST_TOT_RUN: begin
            cmd.scan_run  = 1'b1;
            cmd.scan_kind = SCAN_TOT;
            if (status.scan_done) state_in = ST_MR_LO;
         end
         ST_MR_LO: begin
            cmd.mul_step = MUL_LO;
            if (status.total_zero) state_in = ST_FINISH;
            else                   state_in = ST_MR_HI;
         end
         ST_MR_HI: begin
            cmd.mul_step = MUL_HI;
            state_in     = ST_MR_SUM;
         end
         ST_MR_SUM: begin
            cmd.mul_step = MUL_SUM;
            state_in     = ST_ROW_GO;
         end
         ST_ROW_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_kind  = SCAN_ROW;
            state_in       = ST_ROW_RUN;
         end
         ST_ROW_RUN: begin
            cmd.scan_run  = 1'b1;
            cmd.scan_kind = SCAN_ROW;
            if (status.scan_done) state_in = ST_MC_LO;
         end
         ST_MC_LO: begin
            cmd.mul_step = MUL_LO;
            cmd.mul_col  = 1'b1;
            state_in     = ST_MC_HI;
         end
         ST_MC_HI: begin
            cmd.mul_step = MUL_HI;
            cmd.mul_col  = 1'b1;
            state_in     = ST_MC_SUM;
         end
         ST_MC_SUM: begin
            cmd.mul_step = MUL_SUM;
            cmd.mul_col  = 1'b1;
            state_in     = ST_COL_GO;
         end
         ST_COL_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_kind  = SCAN_COL;
            state_in       = ST_COL_RUN;
         end
         ST_COL_RUN: begin
            cmd.scan_run  = 1'b1;
            cmd.scan_kind = SCAN_COL;
            if (status.scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/s2h_dp.sv
// datapath of the 2d histogram sampler: stores, scan engine, multiply, result register
`default_nettype none

module s2h_dp #(
   parameter int MAX_ROWS   = s2h_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS   = s2h_pkg::DEF_MAX_COLS,
   parameter int COUNT_BITS = s2h_pkg::DEF_COUNT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  s2h_pkg::s2h_cmd_type               cmd,
   output s2h_pkg::s2h_status_type            status,
   input  logic                               csr_valid,
   input  logic [s2h_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [s2h_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [s2h_pkg::IDX_W-1:0]          req_cell_row,
   input  logic [s2h_pkg::IDX_W-1:0]          req_cell_col,
   input  logic [s2h_pkg::CNT_W-1:0]          req_cell_count,
   input  logic [s2h_pkg::RAND_W-1:0]         req_rand_row,
   input  logic [s2h_pkg::RAND_W-1:0]         req_rand_col,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [s2h_pkg::IDX_W-1:0]          rsp_row_pick,
   output logic [s2h_pkg::IDX_W-1:0]          rsp_col_pick,
   output logic [s2h_pkg::VAL_W-1:0]          rsp_row_value,
   output logic [s2h_pkg::VAL_W-1:0]          rsp_col_value,
   output logic [s2h_pkg::CNT_W-1:0]          rsp_picked_count,
   output logic                               rsp_empty_flag
);
   import s2h_pkg::*;

   localparam int RA    = $clog2(MAX_ROWS);
   localparam int CA    = $clog2(MAX_COLS);
   localparam int CW    = RA + CA;
   localparam int NRW   = $clog2(MAX_ROWS + 1);
   localparam int NCW   = $clog2(MAX_COLS + 1);
   localparam int ROW_W = COUNT_BITS + CA;
   localparam int TOT_W = ROW_W + RA;
   localparam int RPW   = RA + 8;
   localparam int CPW   = CA + 8;
   localparam logic [RA-1:0] ROW_TOP = RA'(MAX_ROWS - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS    = 3'd0,
      CSR_COLS    = 3'd1,
      CSR_ROW_OFF = 3'd2,
      CSR_COL_OFF = 3'd3,
      CSR_STEP    = 3'd4
   } csr_index_type;

   // stores
   logic [COUNT_BITS-1:0] cell_mem [2**CW];
   logic [ROW_W-1:0]      rs_mem   [2**RA];

   logic [COUNT_BITS-1:0] cell_rd_ff;
   logic [ROW_W-1:0]      rs_rd_ff;
   logic [CW-1:0]         cell_raddr, cell_waddr;
   logic [RA-1:0]         rs_raddr, rs_waddr;
   logic                  cell_we, rs_we;
   logic [COUNT_BITS-1:0] cell_wdata;
   logic [ROW_W-1:0]      rs_wdata;

   // configuration
   logic [7:0]  rows_ff, cols_ff, step_ff;
   logic [15:0] row_off_ff, col_off_ff;
   logic        dirty_ff, dirty_in;
   logic        csr_hit_cols;

   // captured item
   logic [IDX_W-1:0]      ld_r_ff, ld_c_ff;
   logic [COUNT_BITS-1:0] ld_cnt_ff;
   logic [RAND_W-1:0]     u_ff, v_ff;

   // clear sweep
   logic [CW-1:0] clr_ff;

   // window bounds
   logic [NRW-1:0] nr;
   logic [NCW-1:0] nc;
   logic [RA-1:0]  last_row;
   logic [CA-1:0]  last_col;

   // load path
   logic [RA-1:0]    ld_r_idx;
   logic [CA-1:0]    ld_c_idx;
   logic             ld_in_range, ld_in_window;
   logic [ROW_W-1:0] ld_sum;

   // scan engine
   logic [RA-1:0] iss_r_ff, iss_r_in, pend_r_ff, pend_r_in;
   logic [CA-1:0] iss_c_ff, iss_c_in, pend_c_ff, pend_c_in;
   logic          iss_end_ff, iss_end_in, eol;
   logic          pend_vld_ff, pend_vld_in, pend_last_ff, pend_last_in;
   logic          pend_eol_ff, pend_eol_in;
   logic [TOT_W-1:0] acc_ff, acc_in, total_ff, total_in, sum_r, sum_c;
   logic [ROW_W-1:0] row_acc, rowsum_ff, rowsum_in;
   logic [RA-1:0]    sel_r_ff, sel_r_in;
   logic [CA-1:0]    sel_c_ff, sel_c_in;
   logic [COUNT_BITS-1:0] pick_ff, pick_in;
   logic          live, hit, rs_we_scan;

   // multiply
   logic [RAND_W-1:0] mul_a, mul_b;
   logic [63:0]       mul_x, prod, plo_ff, phi_ff, q;
   logic [TOT_W-1:0]  thr_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_row_pick_ff, rsp_col_pick_ff;
   logic [VAL_W-1:0]  rsp_row_value_ff, rsp_col_value_ff;
   logic [CNT_W-1:0]  rsp_picked_count_ff;
   logic              rsp_empty_flag_ff;
   logic [RPW-1:0]    row_prod;
   logic [CPW-1:0]    col_prod;

   // configuration registers
   assign csr_hit_cols = csr_valid && (csr_index == CSR_COLS);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= ROWS_RST;
         cols_ff    <= COLS_RST;
         row_off_ff <= ROW_OFF_RST;
         col_off_ff <= COL_OFF_RST;
         step_ff    <= STEP_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROWS:    rows_ff    <= csr_wdata[7:0];
            CSR_COLS:    cols_ff    <= csr_wdata[7:0];
            CSR_ROW_OFF: row_off_ff <= csr_wdata;
            CSR_COL_OFF: col_off_ff <= csr_wdata;
            CSR_STEP:    step_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // row sums go stale when the column window changes
   always_comb begin
      dirty_in = dirty_ff;
      if (csr_hit_cols) dirty_in = 1'b1;
      else if (status.scan_done && cmd.scan_kind == SCAN_RESCAN) dirty_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) dirty_ff <= 1'b0;
      else       dirty_ff <= dirty_in;
   end

   // window sizes, zero acts as one, saturate at the table size
   assign nr = (rows_ff == 8'd0) ? NRW'(1) :
               (32'(rows_ff) > 32'(MAX_ROWS)) ? NRW'(MAX_ROWS) : NRW'(rows_ff);
   assign nc = (cols_ff == 8'd0) ? NCW'(1) :
               (32'(cols_ff) > 32'(MAX_COLS)) ? NCW'(MAX_COLS) : NCW'(cols_ff);
   assign last_row = RA'(nr - NRW'(1));
   assign last_col = CA'(nc - NCW'(1));

   // capture of the accepted beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ld_r_ff   <= req_cell_row;
         ld_c_ff   <= req_cell_col;
         ld_cnt_ff <= COUNT_BITS'(req_cell_count);
         u_ff      <= req_rand_row;
         v_ff      <= req_rand_col;
      end
   end

   // clear sweep counter
   always_ff @(posedge clock) begin
      if (reset)               clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
   end

   // load address and row sum update
   assign ld_r_idx     = RA'(ld_r_ff);
   assign ld_c_idx     = CA'(ld_c_ff);
   assign ld_in_range  = (32'(ld_r_ff) < 32'(MAX_ROWS)) && (32'(ld_c_ff) < 32'(MAX_COLS));
   assign ld_in_window = (32'(ld_c_ff) < 32'(nc));
   assign ld_sum       = rs_rd_ff - ROW_W'(cell_rd_ff) + ROW_W'(ld_cnt_ff);

   // scan issue side
   always_comb begin
      iss_r_in     = iss_r_ff;
      iss_c_in     = iss_c_ff;
      iss_end_in   = iss_end_ff;
      pend_vld_in  = 1'b0;
      pend_last_in = 1'b0;
      pend_eol_in  = 1'b0;
      pend_r_in    = iss_r_ff;
      pend_c_in    = iss_c_ff;
      eol          = (iss_c_ff == last_col);
      if (cmd.scan_start) begin
         iss_r_in   = '0;
         iss_c_in   = '0;
         iss_end_in = 1'b0;
      end else if (cmd.scan_run && !iss_end_ff) begin
         pend_vld_in = 1'b1;
         case (cmd.scan_kind)
            SCAN_TOT, SCAN_ROW: begin
               pend_last_in = (iss_r_ff == last_row);
               iss_r_in     = iss_r_ff + 1'b1;
            end
            SCAN_COL: begin
               pend_last_in = eol;
               iss_c_in     = iss_c_ff + 1'b1;
            end
            SCAN_RESCAN: begin
               pend_eol_in  = eol;
               pend_last_in = eol && (iss_r_ff == ROW_TOP);
               if (eol) begin
                  iss_c_in = '0;
                  iss_r_in = iss_r_ff + 1'b1;
               end else begin
                  iss_c_in = iss_c_ff + 1'b1;
               end
            end
            default: ;
         endcase
         iss_end_in = pend_last_in;
      end
   end

   // scan data side
   assign live    = cmd.scan_run && pend_vld_ff;
   assign sum_r   = acc_ff + TOT_W'(rs_rd_ff);
   assign sum_c   = acc_ff + TOT_W'(cell_rd_ff);
   assign row_acc = ((pend_c_ff == '0) ? '0 : ROW_W'(acc_ff)) + ROW_W'(cell_rd_ff);

   always_comb begin
      acc_in     = acc_ff;
      total_in   = total_ff;
      rowsum_in  = rowsum_ff;
      sel_r_in   = sel_r_ff;
      sel_c_in   = sel_c_ff;
      pick_in    = pick_ff;
      hit        = 1'b0;
      rs_we_scan = 1'b0;
      if (cmd.scan_start) begin
         acc_in = '0;
      end else if (live) begin
         case (cmd.scan_kind)
            SCAN_TOT: begin
               acc_in = sum_r;
               if (pend_last_ff) total_in = sum_r;
            end
            SCAN_ROW: begin
               acc_in = sum_r;
               hit    = (sum_r > thr_ff);
               if (hit || pend_last_ff) begin
                  sel_r_in  = pend_r_ff;
                  rowsum_in = rs_rd_ff;
               end
            end
            SCAN_COL: begin
               acc_in = sum_c;
               hit    = (sum_c >= thr_ff);
               if (hit || pend_last_ff) begin
                  sel_c_in = pend_c_ff;
                  pick_in  = cell_rd_ff;
               end
            end
            SCAN_RESCAN: begin
               acc_in     = TOT_W'(row_acc);
               rs_we_scan = pend_eol_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_end_ff  <= 1'b1;
         pend_vld_ff <= 1'b0;
      end else begin
         iss_end_ff  <= iss_end_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_r_ff     <= iss_r_in;
      iss_c_ff     <= iss_c_in;
      pend_r_ff    <= pend_r_in;
      pend_c_ff    <= pend_c_in;
      pend_last_ff <= pend_last_in;
      pend_eol_ff  <= pend_eol_in;
      acc_ff       <= acc_in;
      total_ff     <= total_in;
      rowsum_ff    <= rowsum_in;
      sel_r_ff     <= sel_r_in;
      sel_c_ff     <= sel_c_in;
      pick_ff      <= pick_in;
   end

   // store addressing
   assign rs_raddr   = cmd.ld_read ? ld_r_idx : iss_r_ff;
   assign cell_raddr = cmd.ld_read ? {ld_r_idx, ld_c_idx} :
                       {((cmd.scan_kind == SCAN_COL) ? sel_r_ff : iss_r_ff), iss_c_ff};

   always_comb begin
      cell_we    = 1'b0;
      cell_waddr = {ld_r_idx, ld_c_idx};
      cell_wdata = ld_cnt_ff;
      rs_we      = 1'b0;
      rs_waddr   = ld_r_idx;
      rs_wdata   = ld_sum;
      if (cmd.clear_step) begin
         cell_we    = 1'b1;
         cell_waddr = clr_ff;
         cell_wdata = '0;
         rs_we      = 1'b1;
         rs_waddr   = clr_ff[CW-1:CA];
         rs_wdata   = '0;
      end else if (cmd.ld_write && ld_in_range) begin
         cell_we = 1'b1;
         rs_we   = ld_in_window;
      end else if (rs_we_scan) begin
         rs_we    = 1'b1;
         rs_waddr = pend_r_ff;
         rs_wdata = row_acc;
      end
   end

   // cell store
   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
      cell_rd_ff <= cell_mem[cell_raddr];
   end

   // row sum store
   always_ff @(posedge clock) begin
      if (rs_we) rs_mem[rs_waddr] <= rs_wdata;
      rs_rd_ff <= rs_mem[rs_raddr];
   end

   // fraction times sum, two 32x32 partial products then one add
   assign mul_a = cmd.mul_col ? v_ff : u_ff;
   assign mul_x = cmd.mul_col ? 64'(rowsum_ff) : 64'(total_ff);
   assign mul_b = (cmd.mul_step == MUL_HI) ? mul_x[63:32] : mul_x[31:0];
   assign prod  = 64'(mul_a) * 64'(mul_b);
   assign q     = phi_ff + 64'(plo_ff[63:32]) + 64'(cmd.mul_col && (plo_ff[31:0] != 32'd0));

   always_ff @(posedge clock) begin
      case (cmd.mul_step)
         MUL_LO:  plo_ff <= prod;
         MUL_HI:  phi_ff <= prod;
         MUL_SUM: thr_ff <= TOT_W'(q);
         default: ;
      endcase
   end

   // result register
   assign row_prod = RPW'(sel_r_ff) * RPW'(step_ff);
   assign col_prod = CPW'(sel_c_ff) * CPW'(step_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)                  rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (status.total_zero) begin
            rsp_row_pick_ff     <= '0;
            rsp_col_pick_ff     <= '0;
            rsp_row_value_ff    <= '0;
            rsp_col_value_ff    <= '0;
            rsp_picked_count_ff <= '0;
            rsp_empty_flag_ff   <= 1'b1;
         end else begin
            rsp_row_pick_ff     <= IDX_W'(sel_r_ff);
            rsp_col_pick_ff     <= IDX_W'(sel_c_ff);
            rsp_row_value_ff    <= VAL_W'(row_off_ff) + VAL_W'(row_prod);
            rsp_col_value_ff    <= VAL_W'(col_off_ff) + VAL_W'(col_prod);
            rsp_picked_count_ff <= CNT_W'(pick_ff);
            rsp_empty_flag_ff   <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row_pick     = rsp_row_pick_ff;
   assign rsp_col_pick     = rsp_col_pick_ff;
   assign rsp_row_value    = rsp_row_value_ff;
   assign rsp_col_value    = rsp_col_value_ff;
   assign rsp_picked_count = rsp_picked_count_ff;
   assign rsp_empty_flag   = rsp_empty_flag_ff;

   // status back to the controller
   assign status.clear_done = (clr_ff == '1);
   assign status.scan_done  = live && (hit || pend_last_ff);
   assign status.dirty      = dirty_ff;
   assign status.total_zero = (total_ff == '0);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

`default_nettype wire

FILE: rtl/sample_2d_histogram_inverse_cdf.sv
// top level of the 2d histogram inverse cdf sampler
//
// channel   direction  handshake            beat contents
// req_      in         req_valid/req_stall  mode, cell address and count, two fractions
// rsp_      out        rsp_valid/rsp_stall  row/col picks, bin values, cell count, empty flag
// csr_      in         csr_valid/csr_ready  register index and write data
//
// a load beat reads then writes the stores; a sample walks the row sums in use for the total,
// then up to the hit row, then the cells of that row up to the hit column, with a multiply
// before each of the last two walks. an empty window ends after the total walk.
// the first sample after a cols_in_use write first rebuilds all row sums.
// after reset a clearing pass writes every cell, with req_stall high;
// csr writes are taken at all times.
// a stalled result beat lets the next request in; that sample waits at its result load.
`default_nettype none

module sample_2d_histogram_inverse_cdf #(
   parameter int MAX_ROWS   = s2h_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS   = s2h_pkg::DEF_MAX_COLS,
   parameter int COUNT_BITS = s2h_pkg::DEF_COUNT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_mode,
   input  logic [s2h_pkg::IDX_W-1:0]      req_cell_row,
   input  logic [s2h_pkg::IDX_W-1:0]      req_cell_col,
   input  logic [s2h_pkg::CNT_W-1:0]      req_cell_count,
   input  logic [s2h_pkg::RAND_W-1:0]     req_rand_row,
   input  logic [s2h_pkg::RAND_W-1:0]     req_rand_col,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [s2h_pkg::IDX_W-1:0]      rsp_row_pick,
   output logic [s2h_pkg::IDX_W-1:0]      rsp_col_pick,
   output logic [s2h_pkg::VAL_W-1:0]      rsp_row_value,
   output logic [s2h_pkg::VAL_W-1:0]      rsp_col_value,
   output logic [s2h_pkg::CNT_W-1:0]      rsp_picked_count,
   output logic                           rsp_empty_flag,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [s2h_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [s2h_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import s2h_pkg::*;

   s2h_cmd_type    cmd;
   s2h_status_type status;

   // register writes never wait
   assign csr_ready = 1'b1;

   // controller
   s2h_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   s2h_dp #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_cell_row     (req_cell_row),
      .req_cell_col     (req_cell_col),
      .req_cell_count   (req_cell_count),
      .req_rand_row     (req_rand_row),
      .req_rand_col     (req_rand_col),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_row_pick     (rsp_row_pick),
      .rsp_col_pick     (rsp_col_pick),
      .rsp_row_value    (rsp_row_value),
      .rsp_col_value    (rsp_col_value),
      .rsp_picked_count (rsp_picked_count),
      .rsp_empty_flag   (rsp_empty_flag)
   );

`ifndef SYNTHESIS
   // one item at a time: an accepted beat closes the request side
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while an item is in work");

   // an empty window yields all-zero picks
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_flag) |->
      (rsp_row_pick == '0 && rsp_col_pick == '0 && rsp_picked_count == '0))
      else $error("empty result carries nonzero picks");

   // a result is loaded only when the result register can take it
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result register overwritten");

   // store operations never overlap
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, cmd.ld_read, cmd.ld_write, cmd.scan_run, cmd.out_load}))
      else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

FILE: sim/sample_2d_histogram_inverse_cdf_tb.sv
// self-checking testbench of the 2d histogram inverse cdf sampler
`default_nettype none

module sample_2d_histogram_inverse_cdf_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import s2h_pkg::*;

   localparam int MAX_N = 128;
   localparam int ITEMS_PER_PHASE = 88;
   localparam int N_PHASES = 8;
   localparam int SETTLE_CYCLES = 300;
   localparam int LONG_HOLD = 1500;
   localparam int LONG_HOLD_PHASE = 2;
   localparam int N_DIRECTED = 24;
   localparam longint LIMIT_NS = 3_000_000;

   // beat kinds
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_DRAW = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROWS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_OFF = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COL_OFF = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STEP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LAST    = 3'd7;

   localparam logic [RAND_W-1:0] U_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic              mode;
      logic [IDX_W-1:0]  cell_row;
      logic [IDX_W-1:0]  cell_col;
      logic [CNT_W-1:0]  cell_count;
      logic [RAND_W-1:0] rand_row;
      logic [RAND_W-1:0] rand_col;
   } hist_req_t;

   typedef struct packed {
      logic [IDX_W-1:0] row_pick;
      logic [IDX_W-1:0] col_pick;
      logic [VAL_W-1:0] row_value;
      logic [VAL_W-1:0] col_value;
      logic [CNT_W-1:0] picked_count;
      logic             empty_flag;
   } draw_t;

   typedef struct packed {
      hist_req_t beat;
      logic      typed;
      draw_t     want;
   } directed_row_t;

   typedef struct packed {
      logic [7:0]  rows;
      logic [7:0]  cols;
      logic [15:0] row_off;
      logic [15:0] col_off;
      logic [7:0]  step;
      logic [7:0]  idle_pct;
   } phase_cfg_t;

   // opening checks: empty table, single cell, cells outside the window, last cell in use
   localparam directed_row_t DIRECTED [N_DIRECTED] = '{
      '{'{MODE_DRAW, 7'd0, 7'd0, 24'd0, 32'h0, 32'h0}, 1'b1,
        '{7'd0, 7'd0, 17'd0, 17'd0, 24'd0, 1'b1}},
      '{'{MODE_DRAW, 7'd127, 7'd127, 24'hFFFFFF, U_MAX, U_MAX}, 1'b1,
        '{7'd0, 7'd0, 17'd0, 17'd0, 24'd0, 1'b1}},
      '{'{MODE_LOAD, 7'd0, 7'd0, 24'd5, 32'h0, 32'h0}, 1'b0, '0},
      '{'{MODE_DRAW, 7'd0, 7'd0, 24'd0, 32'h0, 32'h0}, 1'b1,
        '{7'd0, 7'd0, 17'd100, 17'd20, 24'd5, 1'b0}},
      '{'{MODE_DRAW, 7'd0, 7'd0, 24'd0, U_MAX, U_MAX}, 1'b1,
        '{7'd0, 7'd0, 17'd100, 17'd20, 24'd5, 1'b0}},
      '{'{MODE_LOAD, 7'd127, 7'd127, 24'hFFFFFF, 32'h0, 32'h0}, 1'b0, '0},
      '{'{MODE_DRAW, 7'd0, 7'd0, 24'd0, U_MAX, U_MAX}, 1'b1,
        '{7'd0, 7'd0, 17'd100, 17'd20, 24'd5, 1'b0}},
      '{'{MODE_LOAD, 7'd119, 7'd99, 24'hFFFFFF, 32'h0, 32'h0}, 1'b0, '0},
      '{'{MODE_DRAW, 7'd0, 7'd0, 24'd0, U_MAX, 32'h0}, 1'b1,
        '{7'd119, 7'd0, 17'd576, 17'd20, 24'd0, 1'b0}},
      '{'{MODE_DRAW, 7'd0, 7'd0, 24'd0, U_MAX, U_MAX}, 1'b1,
        '{7'd119, 7'd99, 17'd576, 17'd416, 24'hFFFFFF, 1'b0}},
      '{'{MODE_LOAD, 7'd0, 7'd0, 24'd0, 32'h0, 32'h0}, 1'b0, '0},
      '{'{MODE_DRAW, 7'd0, 7'd0, 24'd0, 32'h0, 32'h0}, 1'b1,
        '{7'd119, 7'd0, 17'd576, 17'd20, 24'd0, 1'b0}},
      '{'{MODE_LOAD, 7'd60, 7'd50, 24'd1000, 32'h0, 32'h0}, 1'b0, '0},
      '{'{MODE_LOAD, 7'd60, 7'd10, 24'd300, 32'h0, 32'h0}, 1'b0, '0},
      '{'{MODE_LOAD, 7'd0, 7'd127, 24'd777, 32'h0, 32'h0}, 1'b0, '0},
      '{'{MODE_LOAD, 7'd127, 7'd0, 24'd12345, 32'h0, 32'h0}, 1'b0, '0},
      '{'{MODE_DRAW, 7'd0, 7'd0, 24'd0, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0},
      '{'{MODE_DRAW, 7'd0, 7'd0, 24'd0, 32'h0000_0001, U_MAX}, 1'b0, '0},
      '{'{MODE_DRAW, 7'd0, 7'd0, 24'd0, 32'h5555_5555, 32'h2AAA_AAAA}, 1'b0, '0},
      '{'{MODE_LOAD, 7'd60, 7'd50, 24'h2AAAAA, 32'h0, 32'h0}, 1'b0, '0},
      '{'{MODE_DRAW, 7'd0, 7'd0, 24'd0, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, '0},
      '{'{MODE_DRAW, 7'd0, 7'd0, 24'd0, 32'hC000_0000, 32'h0000_0001}, 1'b0, '0},
      '{'{MODE_LOAD, 7'd1, 7'd1, 24'h555555, 32'h0, 32'h0}, 1'b0, '0},
      '{'{MODE_DRAW, 7'd0, 7'd0, 24'd0, 32'h3000_0000, 32'hFFFF_0000}, 1'b0, '0}
   };

   // register settings per random phase: window extremes, wide values, reset values last
   localparam phase_cfg_t PHASES [N_PHASES] = '{
      '{8'd8,   8'd8,   16'd0,     16'd0,     8'd1,   8'd30},
      '{8'd1,   8'd1,   16'd65535, 16'd65535, 8'd255, 8'd25},
      '{8'd128, 8'd128, 16'd65535, 16'd65535, 8'd255, 8'd40},
      '{8'd0,   8'd0,   16'd1234,  16'd4321,  8'd3,   8'd0},
      '{8'd255, 8'd255, 16'd0,     16'd100,   8'd7,   8'd20},
      '{8'd16,  8'd200, 16'd40000, 16'd0,     8'd128, 8'd50},
      '{8'd3,   8'd128, 16'd500,   16'd65000, 8'd200, 8'd15},
      '{8'd120, 8'd100, 16'd100,   16'd20,    8'd4,   8'd0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_mode;
   logic [IDX_W-1:0]      req_cell_row;
   logic [IDX_W-1:0]      req_cell_col;
   logic [CNT_W-1:0]      req_cell_count;
   logic [RAND_W-1:0]     req_rand_row;
   logic [RAND_W-1:0]     req_rand_col;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [IDX_W-1:0]      rsp_row_pick;
   logic [IDX_W-1:0]      rsp_col_pick;
   logic [VAL_W-1:0]      rsp_row_value;
   logic [VAL_W-1:0]      rsp_col_value;
   logic [CNT_W-1:0]      rsp_picked_count;
   logic                  rsp_empty_flag;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // shadow of the histogram and its registers
   logic [CNT_W-1:0] hist_cells [MAX_N][MAX_N];
   logic [7:0]       rows_reg;
   logic [7:0]       cols_reg;
   logic [15:0]      row_off_reg;
   logic [15:0]      col_off_reg;
   logic [7:0]       step_reg;

   draw_t pending_draws [$];
   int    fail_count = 0;
   int    idle_pct = 20;
   bit    long_hold_req = 1'b0;

   sample_2d_histogram_inverse_cdf dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_cell_row     (req_cell_row),
      .req_cell_col     (req_cell_col),
      .req_cell_count   (req_cell_count),
      .req_rand_row     (req_rand_row),
      .req_rand_col     (req_rand_col),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_pick     (rsp_row_pick),
      .rsp_col_pick     (rsp_col_pick),
      .rsp_row_value    (rsp_row_value),
      .rsp_col_value    (rsp_col_value),
      .rsp_picked_count (rsp_picked_count),
      .rsp_empty_flag   (rsp_empty_flag),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("** sample_2d_histogram_inverse_cdf: FAILED **");
      $finish;
   end

   // zero acts as one, large sizes saturate at the table size
   function automatic int clamp_window(input logic [7:0] n);
      if (n == 8'd0) return 1;
      return (int'(n) > MAX_N) ? MAX_N : int'(n);
   endfunction

   // inverse cdf draw over the current window of the shadow table
   function automatic draw_t predict_draw(input logic [RAND_W-1:0] u,
                                          input logic [RAND_W-1:0] v);
      draw_t       res;
      int          nr, nc, r, c, sel_r, sel_c;
      logic [37:0] row_tot [MAX_N];
      logic [37:0] total, run;
      logic [95:0] prod;
      logic [63:0] thr;
      logic [31:0] val;
      nr = clamp_window(rows_reg);
      nc = clamp_window(cols_reg);
      res = '0;
      total = '0;
      for (r = 0; r < nr; r++) begin
         row_tot[r] = '0;
         for (c = 0; c < nc; c++) row_tot[r] += hist_cells[r][c];
         total += row_tot[r];
      end
      if (total == '0) begin
         res.empty_flag = 1'b1;
         return res;
      end
      // first row whose running sum exceeds floor(u * total)
      prod = u * total;
      thr = prod[95:32];
      sel_r = nr - 1;
      run = '0;
      for (r = 0; r < nr; r++) begin
         run += row_tot[r];
         if (run > thr) begin
            sel_r = r;
            break;
         end
      end
      // first column whose running sum reaches ceil(v * row sum)
      prod = v * row_tot[sel_r];
      thr = prod[95:32] + 64'(prod[31:0] != 32'd0);
      sel_c = nc - 1;
      run = '0;
      for (c = 0; c < nc; c++) begin
         run += hist_cells[sel_r][c];
         if (run >= thr) begin
            sel_c = c;
            break;
         end
      end
      res.row_pick = sel_r[IDX_W-1:0];
      res.col_pick = sel_c[IDX_W-1:0];
      val = 32'(row_off_reg) + 32'(sel_r) * 32'(step_reg);
      res.row_value = val[VAL_W-1:0];
      val = 32'(col_off_reg) + 32'(sel_c) * 32'(step_reg);
      res.col_value = val[VAL_W-1:0];
      res.picked_count = hist_cells[sel_r][sel_c];
      return res;
   endfunction

   // fractions lean toward the ends of the range now and then
   function automatic logic [RAND_W-1:0] draw_fraction();
      case ($urandom_range(9))
         0: return '0;
         1: return U_MAX;
         default: return $urandom;
      endcase
   endfunction

   // offer one beat, optionally after an idle burst, and track it once taken
   task automatic offer_beat(input hist_req_t b, input logic typed, input draw_t want);
      int gap;
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(6, 1);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= b.mode;
      req_cell_row   <= b.cell_row;
      req_cell_col   <= b.cell_col;
      req_cell_count <= b.cell_count;
      req_rand_row   <= b.rand_row;
      req_rand_col   <= b.rand_col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (b.mode == MODE_LOAD)
         hist_cells[b.cell_row][b.cell_col] = b.cell_count;
      else if (typed)
         pending_draws.push_back(want);
      else
         pending_draws.push_back(predict_draw(b.rand_row, b.rand_col));
   endtask

   // one register write beat, shadow updated when taken
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ROWS:    rows_reg = data[7:0];
         REG_COLS:    cols_reg = data[7:0];
         REG_ROW_OFF: row_off_reg = data;
         REG_COL_OFF: col_off_reg = data;
         REG_STEP:    step_reg = data[7:0];
         default: ;
      endcase
   endtask

   // all draws back, then let a trailing load or draw finish
   task automatic wait_drained();
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: random stall bursts plus one long hold-off on request
   initial begin : rsp_throttle
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0)
            hold_left--;
         else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
         end else if ($urandom_range(99) < idle_pct)
            hold_left = $urandom_range(6, 1);
         rsp_stall <= (hold_left > 0);
      end
   end

   // compare each taken result beat with the oldest predicted draw
   always @(posedge clock) begin
      draw_t got, want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         got = '{rsp_row_pick, rsp_col_pick, rsp_row_value, rsp_col_value,
                 rsp_picked_count, rsp_empty_flag};
         if (pending_draws.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected draw beat: row %0d col %0d rv %0d cv %0d cnt %0d empty %0b",
                        got.row_pick, got.col_pick, got.row_value, got.col_value,
                        got.picked_count, got.empty_flag);
            fail_count++;
         end else begin
            want = pending_draws.pop_front();
            if (got.row_pick !== want.row_pick || got.col_pick !== want.col_pick ||
                got.row_value !== want.row_value || got.col_value !== want.col_value ||
                got.picked_count !== want.picked_count ||
                got.empty_flag !== want.empty_flag) begin
               if (fail_count < 10) begin
                  $display("draw mismatch at %0t", $realtime);
                  $display("  want row %0d col %0d rv %0d cv %0d cnt %0d empty %0b",
                           want.row_pick, want.col_pick, want.row_value, want.col_value,
                           want.picked_count, want.empty_flag);
                  $display("  got  row %0d col %0d rv %0d cv %0d cnt %0d empty %0b",
                           got.row_pick, got.col_pick, got.row_value, got.col_value,
                           got.picked_count, got.empty_flag);
               end
               fail_count++;
            end
         end
      end
   end

   // reset, directed table, then randomized phases under several settings
   initial begin : stimulus
      hist_req_t beat;
      int        phase, k, r, c, nr, nc;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_LOAD;
      req_cell_row = '0;
      req_cell_col = '0;
      req_cell_count = '0;
      req_rand_row = '0;
      req_rand_col = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      rows_reg = ROWS_RST;
      cols_reg = COLS_RST;
      row_off_reg = ROW_OFF_RST;
      col_off_reg = COL_OFF_RST;
      step_reg = STEP_RST;
      for (r = 0; r < MAX_N; r++)
         for (c = 0; c < MAX_N; c++) hist_cells[r][c] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows under the reset register values
      for (k = 0; k < N_DIRECTED; k++)
         offer_beat(DIRECTED[k].beat, DIRECTED[k].typed, DIRECTED[k].want);

      for (phase = 0; phase < N_PHASES; phase++) begin
         @(negedge clock);
         req_valid <= 1'b0;
         wait_drained();

         // narrow registers get junk in the upper byte, plus one unused index
         write_reg(REG_ROWS, {8'($urandom), PHASES[phase].rows});
         write_reg(REG_COLS, {8'($urandom), PHASES[phase].cols});
         write_reg(REG_ROW_OFF, PHASES[phase].row_off);
         write_reg(REG_COL_OFF, PHASES[phase].col_off);
         write_reg(REG_STEP, {8'($urandom), PHASES[phase].step});
         write_reg(CSR_IDX_W'($urandom_range(REG_LAST, REG_STEP + 1)), 16'($urandom));
         @(negedge clock);
         csr_valid <= 1'b0;

         idle_pct = PHASES[phase].idle_pct;
         if (phase == LONG_HOLD_PHASE) long_hold_req = 1'b1;
         nr = clamp_window(rows_reg);
         nc = clamp_window(cols_reg);

         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            beat.mode = ($urandom_range(99) < 55) ? MODE_DRAW : MODE_LOAD;
            // most loads land inside the window so draws see real content
            if ($urandom_range(3) != 0) begin
               beat.cell_row = IDX_W'($urandom_range(nr - 1));
               beat.cell_col = IDX_W'($urandom_range(nc - 1));
            end else begin
               beat.cell_row = IDX_W'($urandom);
               beat.cell_col = IDX_W'($urandom);
            end
            case ($urandom_range(9))
               0, 1: beat.cell_count = '0;
               2: beat.cell_count = '1;
               3: beat.cell_count = CNT_W'($urandom);
               default: beat.cell_count = CNT_W'($urandom_range(5000, 1));
            endcase
            beat.rand_row = draw_fraction();
            beat.rand_col = draw_fraction();
            offer_beat(beat, 1'b0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      if (fail_count == 0 && pending_draws.size() == 0)
         $display("** sample_2d_histogram_inverse_cdf: PASSED **");
      else
         $display("** sample_2d_histogram_inverse_cdf: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
